/* rtl/wsg_pkg.sv */
// ----------------------------------------------------------------------------
// wsg_pkg: shared types and constants of the wave surface grid step block
// Command codes, register indexes, reset values and the controller states.
// ----------------------------------------------------------------------------
`default_nettype none

package wsg_pkg;

  // Fixed field widths.
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 18;
  localparam int COEF_W     = 18;
  localparam int DIM_W      = 8;
  localparam int POS_W      = 7;

  // Smallest grid size that has an interior cell.
  localparam int MIN_DIM = 3;

  typedef enum logic [1:0] {
    CMD_WRITE = 2'd0,
    CMD_ADD   = 2'd1,
    CMD_STEP  = 2'd2,
    CMD_READ  = 2'd3
  } cmd_e;

  localparam logic [CFG_IDX_W-1:0] CFG_COEF_CENTER    = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_COEF_PREVIOUS  = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_COEF_NEIGHBOUR = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_GRID_COLS      = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_GRID_ROWS      = 3'd4;

  localparam logic signed [COEF_W-1:0] COEF_CENTER_RST    = 18'sd130110;
  localparam logic signed [COEF_W-1:0] COEF_PREVIOUS_RST  = -18'sd65531;
  localparam logic signed [COEF_W-1:0] COEF_NEIGHBOUR_RST = 18'sd236;
  localparam logic [DIM_W-1:0]         GRID_DIM_RST       = 8'd100;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_ACC,
    ST_PRE,
    ST_NS,
    ST_E,
    ST_DRAIN,
    ST_RESP
  } state_e;

  // What the memory read ports were asked for in the previous cycle.
  typedef enum logic [1:0] {
    TAG_NONE,
    TAG_PRE,
    TAG_NS,
    TAG_E
  } rd_tag_e;

endpackage

`default_nettype wire

/* rtl/wave_surface_grid_step.sv */
// ----------------------------------------------------------------------------
// wave_surface_grid_step: damped wave equation on a two-dimensional grid
// Two height memories hold the current and previous grids; commands write,
// stimulate or read a cell, or advance the whole surface by one time step.
// ----------------------------------------------------------------------------
// Usage. Items arrive on the in channel (cmd, cell_row, cell_col, value) and
// each one yields exactly one item on the out channel (height, saturated).
// Registers are written over the cfg channel, which is always ready; they
// must only change while no command is in flight.
// Sequence: a write, or an address outside the grid, goes from the idle state
// straight to ST_RESP, which loads the result into the output register once
// that is free; a read or add passes ST_ACC first, and the next item is taken
// once ST_RESP is left. A step reads the current grid through the two read
// ports of its memory: each row starts with a prefetch of the west and center
// heights, then each interior cell fetches north and south, then east, and a
// pipeline drain follows; a grid with fewer than three rows or columns goes
// straight to the drain. Commands are handled one at a time.
// Reset: both memories are swept to zero, one address per cycle; in_ready_o
// stays low during the sweep. Register writes are taken during the sweep as
// at any time.
// Stall: a result waits in the output register while the next item is
// accepted; that item's result is held back until the first one is taken.
// ----------------------------------------------------------------------------
`default_nettype none

module wave_surface_grid_step import wsg_pkg::*; #(
  parameter int MAX_COLS    = 128,
  parameter int MAX_ROWS    = 128,
  parameter int HEIGHT_BITS = 16
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,

  input  logic                          cfg_valid_i,
  output logic                          cfg_ready_o,
  input  logic [CFG_IDX_W-1:0]          cfg_index_i,
  input  logic [CFG_DATA_W-1:0]         cfg_data_i,

  input  logic                          in_valid_i,
  output logic                          in_ready_o,
  input  logic [1:0]                    cmd_i,
  input  logic [POS_W-1:0]              cell_row_i,
  input  logic [POS_W-1:0]              cell_col_i,
  input  logic signed [HEIGHT_BITS-1:0] value_i,

  output logic                          out_valid_o,
  input  logic                          out_ready_i,
  output logic signed [HEIGHT_BITS-1:0] height_o,
  output logic                          saturated_o
);

  // Memory geometry: row-major with a stride of MAX_COLS.
  localparam int DEPTH  = MAX_ROWS * MAX_COLS;
  localparam int ADDR_W = $clog2(DEPTH);
  localparam int H      = HEIGHT_BITS;

  // Datapath widths of the step arithmetic.
  localparam int NSUM_W = H + 2;
  localparam int PC_W   = COEF_W + H;
  localparam int PN_W   = COEF_W + NSUM_W;
  localparam int ACC_W  = PN_W + 2;
  localparam int RND_W  = ACC_W - 16;

  localparam logic signed [RND_W-1:0] RND_MAX = {{(RND_W-H+1){1'b0}}, {(H-1){1'b1}}};
  localparam logic signed [RND_W-1:0] RND_MIN = ~RND_MAX;
  localparam logic signed [H:0]       ADD_MAX = {2'b00, {(H-1){1'b1}}};
  localparam logic signed [H:0]       ADD_MIN = ~ADD_MAX;
  localparam logic signed [H-1:0]     H_MAX   = {1'b0, {(H-1){1'b1}}};
  localparam logic signed [H-1:0]     H_MIN   = ~H_MAX;
  localparam logic signed [ACC_W-1:0] RND_HALF = ACC_W'(32768);

  function automatic logic [ADDR_W-1:0] cell_addr(input logic [DIM_W-1:0] r,
                                                  input logic [DIM_W-1:0] c);
    cell_addr = ADDR_W'(r) * ADDR_W'(MAX_COLS) + ADDR_W'(c);
  endfunction

  // --------------------------------------------------------------------------
  // Configuration registers
  // --------------------------------------------------------------------------
  logic signed [COEF_W-1:0] coef_center_q, coef_previous_q, coef_neighbour_q;
  logic [DIM_W-1:0]         grid_cols_q, grid_rows_q;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      coef_center_q    <= COEF_CENTER_RST;
      coef_previous_q  <= COEF_PREVIOUS_RST;
      coef_neighbour_q <= COEF_NEIGHBOUR_RST;
      grid_cols_q      <= GRID_DIM_RST;
      grid_rows_q      <= GRID_DIM_RST;
    end else if (cfg_valid_i) begin
      case (cfg_index_i)
        CFG_COEF_CENTER:    coef_center_q    <= $signed(cfg_data_i);
        CFG_COEF_PREVIOUS:  coef_previous_q  <= $signed(cfg_data_i);
        CFG_COEF_NEIGHBOUR: coef_neighbour_q <= $signed(cfg_data_i);
        CFG_GRID_COLS:      grid_cols_q      <= cfg_data_i[DIM_W-1:0];
        CFG_GRID_ROWS:      grid_rows_q      <= cfg_data_i[DIM_W-1:0];
        default: ;
      endcase
    end
  end

  // Grid size in use, limited to the size of the memories.
  logic [DIM_W-1:0] cols_used, rows_used;
  logic             step_ok, in_range;

  assign cols_used = (32'(grid_cols_q) > MAX_COLS) ? DIM_W'(MAX_COLS) : grid_cols_q;
  assign rows_used = (32'(grid_rows_q) > MAX_ROWS) ? DIM_W'(MAX_ROWS) : grid_rows_q;
  assign step_ok   = (32'(cols_used) >= MIN_DIM) && (32'(rows_used) >= MIN_DIM);
  assign in_range  = (DIM_W'(cell_row_i) < rows_used) && (DIM_W'(cell_col_i) < cols_used);

  // --------------------------------------------------------------------------
  // Height memories. Each has two read ports and one write port. The flag
  // a_cur_q selects which one plays the current grid; the other one is the
  // previous grid and receives the results of a step.
  // --------------------------------------------------------------------------
  logic signed [H-1:0] mem_a [DEPTH];
  logic signed [H-1:0] mem_b [DEPTH];
  logic signed [H-1:0] a_rd0_q, a_rd1_q, b_rd0_q, b_rd1_q;
  logic [ADDR_W-1:0]   a_ra0, a_ra1, b_ra0, b_ra1;
  logic                a_we, b_we;
  logic [ADDR_W-1:0]   wa;
  logic signed [H-1:0] wd;
  logic                a_cur_q;

  always_ff @(posedge clk_i) begin
    if (a_we) begin
      mem_a[wa] <= wd;
    end
    a_rd0_q <= mem_a[a_ra0];
    a_rd1_q <= mem_a[a_ra1];
  end

  always_ff @(posedge clk_i) begin
    if (b_we) begin
      mem_b[wa] <= wd;
    end
    b_rd0_q <= mem_b[b_ra0];
    b_rd1_q <= mem_b[b_ra1];
  end

  // Role-based view of the ports.
  logic [ADDR_W-1:0]   cur_ra0, cur_ra1, prev_ra0;
  logic                we_cur, we_prev, we_both;
  logic signed [H-1:0] cur_rd0, cur_rd1, prev_rd0;

  assign a_ra0 = a_cur_q ? cur_ra0 : prev_ra0;
  assign b_ra0 = a_cur_q ? prev_ra0 : cur_ra0;
  assign a_ra1 = cur_ra1;
  assign b_ra1 = cur_ra1;
  assign a_we  = we_both | (a_cur_q ? we_cur : we_prev);
  assign b_we  = we_both | (a_cur_q ? we_prev : we_cur);

  assign cur_rd0  = a_cur_q ? a_rd0_q : b_rd0_q;
  assign cur_rd1  = a_cur_q ? a_rd1_q : b_rd1_q;
  assign prev_rd0 = a_cur_q ? b_rd0_q : a_rd0_q;

  // --------------------------------------------------------------------------
  // Controller state
  // --------------------------------------------------------------------------
  state_e              state_q, state_d;
  rd_tag_e             rd_tag_q, rd_tag_d;
  logic [ADDR_W-1:0]   clr_q, clr_d;
  logic [DIM_W-1:0]    row_q, row_d, col_q, col_d;
  cmd_e                cmd_q;
  logic [ADDR_W-1:0]   op_addr_q;
  logic signed [H-1:0] op_value_q;
  logic signed [H-1:0] resp_h_q, resp_h_d;
  logic                resp_sat_q, resp_sat_d;
  logic                op_capture, step_start, toggle_cur, out_load;
  logic                fsm_we_cur, fsm_we_both;
  logic [ADDR_W-1:0]   fsm_wa;
  logic signed [H-1:0] fsm_wd;

  // Step pipeline: multiply stage, then sum and round stage, then write.
  logic                     p_valid_q, w_valid_q, step_sat_q;
  logic [ADDR_W-1:0]        e_addr_q, p_addr_q, w_addr_q;
  logic signed [H-1:0]      w_data_q;
  logic signed [RND_W-1:0]  rnd;

  logic [ADDR_W-1:0]   in_addr, cur_addr;
  logic signed [H:0]   add_sum;
  logic signed [H-1:0] add_clip;
  logic                add_sat;
  logic [DIM_W:0]      col_next, row_next;

  assign in_addr  = cell_addr(DIM_W'(cell_row_i), DIM_W'(cell_col_i));
  assign cur_addr = cell_addr(row_q, col_q);
  assign col_next = (DIM_W+1)'(col_q) + (DIM_W+1)'(2);
  assign row_next = (DIM_W+1)'(row_q) + (DIM_W+1)'(2);

  // Saturating add of a stimulus to the current height.
  always_comb begin
    add_sum = (H+1)'(cur_rd0) + (H+1)'(op_value_q);
    add_sat = 1'b0;
    if (add_sum > ADD_MAX) begin
      add_clip = H_MAX;
      add_sat  = 1'b1;
    end else if (add_sum < ADD_MIN) begin
      add_clip = H_MIN;
      add_sat  = 1'b1;
    end else begin
      add_clip = add_sum[H-1:0];
    end
  end

  assign in_ready_o = (state_q == ST_IDLE);

  always_comb begin
    state_d     = state_q;
    rd_tag_d    = TAG_NONE;
    clr_d       = clr_q;
    row_d       = row_q;
    col_d       = col_q;
    resp_h_d    = resp_h_q;
    resp_sat_d  = resp_sat_q;
    op_capture  = 1'b0;
    step_start  = 1'b0;
    toggle_cur  = 1'b0;
    out_load    = 1'b0;
    cur_ra0     = '0;
    cur_ra1     = '0;
    prev_ra0    = '0;
    fsm_we_cur  = 1'b0;
    fsm_we_both = 1'b0;
    fsm_wa      = op_addr_q;
    fsm_wd      = '0;

    case (state_q)
      ST_CLEAR: begin
        fsm_we_both = 1'b1;
        fsm_wa      = clr_q;
        if (clr_q == ADDR_W'(DEPTH - 1)) begin
          state_d = ST_IDLE;
        end else begin
          clr_d = clr_q + ADDR_W'(1);
        end
      end

      ST_IDLE: begin
        if (in_valid_i) begin
          op_capture = 1'b1;
          if (cmd_e'(cmd_i) == CMD_STEP) begin
            step_start = 1'b1;
            row_d      = DIM_W'(1);
            col_d      = DIM_W'(1);
            state_d    = step_ok ? ST_PRE : ST_DRAIN;
          end else if (!in_range) begin
            resp_h_d   = '0;
            resp_sat_d = 1'b0;
            state_d    = ST_RESP;
          end else begin
            case (cmd_e'(cmd_i))
              CMD_WRITE: begin
                // The value already fits the height range, so it never clips.
                fsm_we_both = 1'b1;
                fsm_wa      = in_addr;
                fsm_wd      = value_i;
                resp_h_d    = value_i;
                resp_sat_d  = 1'b0;
                state_d     = ST_RESP;
              end
              CMD_ADD, CMD_READ: begin
                cur_ra0 = in_addr;
                state_d = ST_ACC;
              end
              default: begin
                state_d = ST_RESP;
              end
            endcase
          end
        end
      end

      ST_ACC: begin
        if (cmd_q == CMD_ADD) begin
          fsm_we_cur = 1'b1;
          fsm_wa     = op_addr_q;
          fsm_wd     = add_clip;
          resp_h_d   = add_clip;
          resp_sat_d = add_sat;
        end else begin
          resp_h_d   = cur_rd0;
          resp_sat_d = 1'b0;
        end
        state_d = ST_RESP;
      end

      // Row start: fetch the west and center heights of the first cell.
      ST_PRE: begin
        cur_ra0  = cur_addr - ADDR_W'(1);
        cur_ra1  = cur_addr;
        rd_tag_d = TAG_PRE;
        state_d  = ST_NS;
      end

      ST_NS: begin
        cur_ra0  = cur_addr - ADDR_W'(MAX_COLS);
        cur_ra1  = cur_addr + ADDR_W'(MAX_COLS);
        rd_tag_d = TAG_NS;
        state_d  = ST_E;
      end

      // East neighbour from the current grid, own cell from the previous.
      ST_E: begin
        cur_ra0  = cur_addr + ADDR_W'(1);
        prev_ra0 = cur_addr;
        rd_tag_d = TAG_E;
        if (col_next < (DIM_W+1)'(cols_used)) begin
          col_d   = col_q + DIM_W'(1);
          state_d = ST_NS;
        end else if (row_next < (DIM_W+1)'(rows_used)) begin
          row_d   = row_q + DIM_W'(1);
          col_d   = DIM_W'(1);
          state_d = ST_PRE;
        end else begin
          state_d = ST_DRAIN;
        end
      end

      // Wait for the last results to land, then swap the grids.
      ST_DRAIN: begin
        if (rd_tag_q == TAG_NONE && !p_valid_q && !w_valid_q) begin
          toggle_cur = 1'b1;
          resp_h_d   = '0;
          resp_sat_d = step_sat_q;
          state_d    = ST_RESP;
        end
      end

      ST_RESP: begin
        if (!out_valid_o || out_ready_i) begin
          out_load = 1'b1;
          state_d  = ST_IDLE;
        end
      end

      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  // Step results have the write port whenever they are in flight.
  assign we_prev = w_valid_q;
  assign we_cur  = fsm_we_cur;
  assign we_both = fsm_we_both;
  assign wa      = w_valid_q ? w_addr_q : fsm_wa;
  assign wd      = w_valid_q ? w_data_q : fsm_wd;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_CLEAR;
      rd_tag_q    <= TAG_NONE;
      clr_q       <= '0;
      a_cur_q     <= 1'b1;
      p_valid_q   <= 1'b0;
      w_valid_q   <= 1'b0;
      step_sat_q  <= 1'b0;
      out_valid_o <= 1'b0;
    end else begin
      state_q   <= state_d;
      rd_tag_q  <= rd_tag_d;
      clr_q     <= clr_d;
      p_valid_q <= (rd_tag_q == TAG_E);
      w_valid_q <= p_valid_q;
      if (toggle_cur) begin
        a_cur_q <= ~a_cur_q;
      end
      if (step_start) begin
        step_sat_q <= 1'b0;
      end else if (p_valid_q && (rnd > RND_MAX || rnd < RND_MIN)) begin
        step_sat_q <= 1'b1;
      end
      if (out_load) begin
        out_valid_o <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_o <= 1'b0;
      end
    end
  end

  // Command payload and result registers.
  always_ff @(posedge clk_i) begin
    row_q      <= row_d;
    col_q      <= col_d;
    resp_h_q   <= resp_h_d;
    resp_sat_q <= resp_sat_d;
    if (op_capture) begin
      cmd_q      <= cmd_e'(cmd_i);
      op_addr_q  <= in_addr;
      op_value_q <= value_i;
    end
    if (out_load) begin
      height_o    <= resp_h_q;
      saturated_o <= resp_sat_q;
    end
  end

  // --------------------------------------------------------------------------
  // Stencil window and arithmetic. The west and center heights slide along
  // the row; north, south and east are fetched for each cell.
  // --------------------------------------------------------------------------
  logic signed [H-1:0]      win_w_q, win_c_q, win_n_q, win_s_q;
  logic signed [NSUM_W-1:0] nsum;
  logic signed [PC_W-1:0]   prod_c_q, prod_p_q;
  logic signed [PN_W-1:0]   prod_n_q;
  logic signed [ACC_W-1:0]  acc;
  logic signed [H-1:0]      rnd_clip;

  assign nsum = NSUM_W'(win_n_q) + NSUM_W'(win_s_q) + NSUM_W'(cur_rd0) + NSUM_W'(win_w_q);

  // Round half up, then floor: an arithmetic shift after adding one half.
  assign acc = ACC_W'(prod_c_q) + ACC_W'(prod_p_q) + ACC_W'(prod_n_q) + RND_HALF;
  assign rnd = $signed(acc[ACC_W-1:16]);

  always_comb begin
    if (rnd > RND_MAX) begin
      rnd_clip = H_MAX;
    end else if (rnd < RND_MIN) begin
      rnd_clip = H_MIN;
    end else begin
      rnd_clip = rnd[H-1:0];
    end
  end

  always_ff @(posedge clk_i) begin
    e_addr_q <= cur_addr;
    case (rd_tag_q)
      TAG_PRE: begin
        win_w_q <= cur_rd0;
        win_c_q <= cur_rd1;
      end
      TAG_NS: begin
        win_n_q <= cur_rd0;
        win_s_q <= cur_rd1;
      end
      TAG_E: begin
        prod_c_q <= PC_W'(coef_center_q) * PC_W'(win_c_q);
        prod_p_q <= PC_W'(coef_previous_q) * PC_W'(prev_rd0);
        prod_n_q <= PN_W'(coef_neighbour_q) * PN_W'(nsum);
        p_addr_q <= e_addr_q;
        win_w_q  <= win_c_q;
        win_c_q  <= cur_rd0;
      end
      default: ;
    endcase
    if (p_valid_q) begin
      w_addr_q <= p_addr_q;
      w_data_q <= rnd_clip;
    end
  end

endmodule

`default_nettype wire

/* tb/wave_surface_grid_step_tb.sv */
// ----------------------------------------------------------------------------
// wave_surface_grid_step_tb: self-checking bench for the wave surface grid
// A predictor keeps its own copy of both height grids and the coefficients,
// works out the result of every accepted command item and checks the height
// and clipping flag of each returned item, in order, under random backpressure.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module wave_surface_grid_step_tb import wsg_pkg::*; ();

  // The block is built at its default size; the predictor uses the same stride.
  localparam int GRID_W = 128;
  localparam int GRID_H = 128;
  localparam int HB     = 16;
  localparam int HMAX   = 32767;
  localparam int HMIN   = -32768;

  // A full 128 by 128 step and the clearing sweep after reset both run without
  // any handshake, so the limit sits well above either of them.
  localparam int QUIET_LIMIT = 150000;
  // Cycles of silence kept at the end to catch a stray result item.
  localparam int TAIL_CYCLES = 40;

  typedef struct packed {
    cmd_e                    cmd;
    logic [POS_W-1:0]        row;
    logic [POS_W-1:0]        col;
    logic signed [HB-1:0]    value;
  } surface_cmd_t;

  typedef struct packed {
    cmd_e                    cmd;
    logic signed [HB-1:0]    height;
    logic                    clipped;
  } surface_result_t;

  // Clock, reset and every input of the block start at known values.
  logic                  clk_i = 1'b0;
  logic                  rst_ni = 1'b0;
  logic                  cfg_valid_i = 1'b0;
  logic                  cfg_ready_o;
  logic [CFG_IDX_W-1:0]  cfg_index_i = '0;
  logic [CFG_DATA_W-1:0] cfg_data_i = '0;
  logic                  in_valid_i = 1'b0;
  logic                  in_ready_o;
  logic [1:0]            cmd_i = '0;
  logic [POS_W-1:0]      cell_row_i = '0;
  logic [POS_W-1:0]      cell_col_i = '0;
  logic signed [HB-1:0]  value_i = '0;
  logic                  out_valid_o;
  logic                  out_ready_i = 1'b0;
  logic signed [HB-1:0]  height_o;
  logic                  saturated_o;

  always #5 clk_i = ~clk_i;

  wave_surface_grid_step #(
    .MAX_COLS   (GRID_W),
    .MAX_ROWS   (GRID_H),
    .HEIGHT_BITS(HB)
  ) dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_valid_i(cfg_valid_i),
    .cfg_ready_o(cfg_ready_o),
    .cfg_index_i(cfg_index_i),
    .cfg_data_i (cfg_data_i),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .cmd_i      (cmd_i),
    .cell_row_i (cell_row_i),
    .cell_col_i (cell_col_i),
    .value_i    (value_i),
    .out_valid_o(out_valid_o),
    .out_ready_i(out_ready_i),
    .height_o   (height_o),
    .saturated_o(saturated_o)
  );

  // --------------------------------------------------------------------------
  // Predictor state: both grids, the role flag and the register copies.
  // --------------------------------------------------------------------------
  int   grid_a [GRID_W*GRID_H];
  int   grid_b [GRID_W*GRID_H];
  logic a_is_cur;
  int   coef_c, coef_p, coef_n;
  int   cols_cfg, rows_cfg;

  // Command items waiting for the driver, and results waiting for the block.
  surface_cmd_t    cmd_backlog[$];
  surface_result_t height_due[$];
  surface_cmd_t    in_flight;
  surface_result_t result_head;

  int send_idle_pct;
  int take_stall_pct;
  int err_count;
  int results_checked;
  int clipped_seen;
  int settings_used;
  int cmd_seen[4];
  int quiet_cycles;

  // Sizes above the grid store act as the store size.
  function automatic int rows_live();
    return (rows_cfg > GRID_H) ? GRID_H : rows_cfg;
  endfunction

  function automatic int cols_live();
    return (cols_cfg > GRID_W) ? GRID_W : cols_cfg;
  endfunction

  function automatic int cur_h(int i);
    return a_is_cur ? grid_a[i] : grid_b[i];
  endfunction

  function automatic int prev_h(int i);
    return a_is_cur ? grid_b[i] : grid_a[i];
  endfunction

  function automatic int clamp_height(longint x);
    if (x > HMAX) return HMAX;
    if (x < HMIN) return HMIN;
    return int'(x);
  endfunction

  // One time step. Products are exact Q10.24 values; the sum is rounded half
  // up to Q8.8 by an arithmetic shift, which floors, and then clipped. Only
  // interior cells of the previous grid are rewritten before the roles swap.
  function automatic logic step_surface();
    int     rows, cols, r, c, i, v;
    longint nsum, acc, rounded;
    logic   clipped;
    rows = rows_live();
    cols = cols_live();
    clipped = 1'b0;
    for (r = 1; r + 1 < rows; r++) begin
      for (c = 1; c + 1 < cols; c++) begin
        i = r * GRID_W + c;
        nsum = longint'(cur_h(i + 1)) + longint'(cur_h(i - 1))
             + longint'(cur_h(i + GRID_W)) + longint'(cur_h(i - GRID_W));
        acc = longint'(coef_c) * longint'(cur_h(i)) + longint'(coef_p) * longint'(prev_h(i))
            + longint'(coef_n) * nsum;
        rounded = (acc + 64'sd32768) >>> 16;
        v = clamp_height(rounded);
        if (longint'(v) != rounded) clipped = 1'b1;
        if (a_is_cur) begin
          grid_b[i] = v;
        end else begin
          grid_a[i] = v;
        end
      end
    end
    a_is_cur = !a_is_cur;
    return clipped;
  endfunction

  // Applies one command item to the predicted surface and returns the result
  // item the block should give back for it.
  function automatic surface_result_t apply_command(surface_cmd_t c);
    surface_result_t res;
    int              i, sum, v;
    res.cmd = c.cmd;
    res.height = '0;
    res.clipped = 1'b0;
    if (c.cmd == CMD_STEP) begin
      res.clipped = step_surface();
    end else if (int'(c.row) < rows_live() && int'(c.col) < cols_live()) begin
      // Addresses outside the grid in use touch nothing and read back zero.
      i = int'(c.row) * GRID_W + int'(c.col);
      case (c.cmd)
        CMD_WRITE: begin
          grid_a[i] = int'(c.value);
          grid_b[i] = int'(c.value);
        end
        CMD_ADD: begin
          sum = cur_h(i) + int'(c.value);
          v = clamp_height(longint'(sum));
          res.clipped = (v != sum);
          if (a_is_cur) begin
            grid_a[i] = v;
          end else begin
            grid_b[i] = v;
          end
        end
        default: begin
        end
      endcase
      res.height = HB'(cur_h(i));
    end
    return res;
  endfunction

  // --------------------------------------------------------------------------
  // Driver: offers queued command items, idling at random between them. The
  // prediction is made at the edge where an item is accepted.
  // --------------------------------------------------------------------------
  always @(posedge clk_i) begin
    if (!rst_ni) begin
      in_valid_i <= 1'b0;
    end else begin
      if (in_valid_i && in_ready_o) begin
        height_due.push_back(apply_command(in_flight));
        cmd_seen[in_flight.cmd]++;
      end
      if (!in_valid_i || in_ready_o) begin
        if (cmd_backlog.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
          in_flight = cmd_backlog.pop_front();
          cmd_i <= in_flight.cmd;
          cell_row_i <= in_flight.row;
          cell_col_i <= in_flight.col;
          value_i <= in_flight.value;
          in_valid_i <= 1'b1;
        end else begin
          in_valid_i <= 1'b0;
        end
      end
    end
  end

  // --------------------------------------------------------------------------
  // Monitor: takes result items under random stalls and checks each against
  // the oldest prediction.
  // --------------------------------------------------------------------------
  always @(posedge clk_i) begin
    if (!rst_ni) begin
      out_ready_i <= 1'b0;
    end else begin
      if (out_valid_o && out_ready_i) begin
        if (height_due.size() == 0) begin
          $display("%0t: result item with none expected: height %0d saturated %0b",
                   $time, height_o, saturated_o);
          err_count++;
        end else begin
          result_head = height_due.pop_front();
          results_checked++;
          if (result_head.clipped) clipped_seen++;
          if (height_o !== result_head.height) begin
            $display("%0t: height after %s: expected %0d, got %0d",
                     $time, result_head.cmd.name(), result_head.height, height_o);
            err_count++;
          end
          if (saturated_o !== result_head.clipped) begin
            $display("%0t: saturated after %s: expected %0b, got %0b",
                     $time, result_head.cmd.name(), result_head.clipped, saturated_o);
            err_count++;
          end
        end
      end
      out_ready_i <= ($urandom_range(99) >= take_stall_pct);
    end
  end

  // Watchdog: ends the run when no handshake of any kind happens for too long.
  always @(posedge clk_i) begin
    if ((in_valid_i && in_ready_o) || (out_valid_o && out_ready_i) ||
        (cfg_valid_i && cfg_ready_o)) begin
      quiet_cycles = 0;
    end else begin
      quiet_cycles++;
    end
    if (quiet_cycles >= QUIET_LIMIT) begin
      $display("%0t: no handshake for %0d cycles, %0d result items outstanding",
               $time, QUIET_LIMIT, height_due.size());
      $display("wave_surface_grid_step_tb: errors");
      $finish;
    end
  end

  // --------------------------------------------------------------------------
  // Stimulus helpers.
  // --------------------------------------------------------------------------
  task automatic queue_cmd(cmd_e c, int row, int col, int value);
    surface_cmd_t it;
    it.cmd = c;
    it.row = POS_W'(row);
    it.col = POS_W'(col);
    it.value = HB'(value);
    cmd_backlog.push_back(it);
  endtask

  // Mostly well-formed traffic on cells inside the grid with modest values;
  // the rest reaches anywhere in the address space with any value.
  task automatic queue_random();
    int   pick, row, col, value;
    cmd_e c;
    pick = $urandom_range(99);
    if (pick < 30) c = CMD_WRITE;
    else if (pick < 55) c = CMD_ADD;
    else if (pick < 70) c = CMD_STEP;
    else c = CMD_READ;
    if ($urandom_range(99) < 85) begin
      row = $urandom_range(rows_live() - 1);
      col = $urandom_range(cols_live() - 1);
    end else begin
      row = $urandom_range(127);
      col = $urandom_range(127);
    end
    if ($urandom_range(99) < 70) value = int'($urandom_range(4096)) - 2048;
    else value = $urandom;
    queue_cmd(c, row, col, value);
  endtask

  // Waits until every queued item has gone in and every result has come out.
  task automatic wait_drained();
    while (cmd_backlog.size() != 0 || in_valid_i || height_due.size() != 0)
      @(posedge clk_i);
  endtask

  // Writes one register and updates the predictor's copy once it is taken.
  // Called at a rising edge; leaves the write request raised.
  task automatic write_register(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
    cfg_index_i <= idx;
    cfg_data_i <= data;
    cfg_valid_i <= 1'b1;
    @(posedge clk_i);
    while (!cfg_ready_o) @(posedge clk_i);
    case (idx)
      CFG_COEF_CENTER:    coef_c = int'($signed(data));
      CFG_COEF_PREVIOUS:  coef_p = int'($signed(data));
      CFG_COEF_NEIGHBOUR: coef_n = int'($signed(data));
      CFG_GRID_COLS:      cols_cfg = int'(data[DIM_W-1:0]);
      CFG_GRID_ROWS:      rows_cfg = int'(data[DIM_W-1:0]);
      default: begin
      end
    endcase
  endtask

  // Writes all five registers. The unused upper bits of the size writes carry
  // random junk, which the block must ignore.
  task automatic configure(int k_center, int k_prev, int k_neigh, int cols, int rows);
    logic [CFG_DATA_W-DIM_W-1:0] junk;
    write_register(CFG_COEF_CENTER, k_center[CFG_DATA_W-1:0]);
    write_register(CFG_COEF_PREVIOUS, k_prev[CFG_DATA_W-1:0]);
    write_register(CFG_COEF_NEIGHBOUR, k_neigh[CFG_DATA_W-1:0]);
    junk = (CFG_DATA_W-DIM_W)'($urandom);
    write_register(CFG_GRID_COLS, {junk, cols[DIM_W-1:0]});
    junk = (CFG_DATA_W-DIM_W)'($urandom);
    write_register(CFG_GRID_ROWS, {junk, rows[DIM_W-1:0]});
    cfg_valid_i <= 1'b0;
    settings_used++;
  endtask

  // --------------------------------------------------------------------------
  // Test sequence.
  // --------------------------------------------------------------------------
  initial begin
    int p, n, dim_r, dim_c;
    for (n = 0; n < GRID_W * GRID_H; n++) begin
      grid_a[n] = 0;
      grid_b[n] = 0;
    end
    a_is_cur = 1'b1;
    coef_c = int'(COEF_CENTER_RST);
    coef_p = int'(COEF_PREVIOUS_RST);
    coef_n = int'(COEF_NEIGHBOUR_RST);
    cols_cfg = int'(GRID_DIM_RST);
    rows_cfg = int'(GRID_DIM_RST);
    err_count = 0;
    results_checked = 0;
    clipped_seen = 0;
    settings_used = 1;
    quiet_cycles = 0;
    for (n = 0; n < 4; n++) cmd_seen[n] = 0;
    send_idle_pct = 19;
    take_stall_pct = 19;

    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Reset settings on a 100 by 100 grid: cleared cells read zero, writes of
    // both height extremes, adds that clip at either end, addresses just past
    // the grid in use, and one step under the reset coefficients.
    queue_cmd(CMD_READ, 0, 0, 0);
    queue_cmd(CMD_WRITE, 1, 1, HMAX);
    queue_cmd(CMD_WRITE, 2, 1, HMIN);
    queue_cmd(CMD_WRITE, 1, 2, 256);
    queue_cmd(CMD_ADD, 1, 1, 1);
    queue_cmd(CMD_ADD, 2, 1, -1);
    queue_cmd(CMD_WRITE, 99, 99, -5);
    queue_cmd(CMD_ADD, 100, 5, 9);
    queue_cmd(CMD_READ, 5, 100, 0);
    queue_cmd(CMD_STEP, 0, 0, 0);
    queue_cmd(CMD_READ, 1, 2, 0);
    wait_drained();

    // Column count above the store width acts as the full width; coefficient
    // extremes on the full grid. The add on the top border is lost after the
    // step, since the grid that becomes current never saw it.
    configure(-131072, 131071, 131071, 255, 128);
    queue_cmd(CMD_WRITE, 127, 127, HMIN);
    queue_cmd(CMD_WRITE, 126, 126, HMAX);
    queue_cmd(CMD_ADD, 0, 127, -1000);
    queue_cmd(CMD_STEP, 0, 0, 0);
    queue_cmd(CMD_READ, 126, 126, 0);
    queue_cmd(CMD_READ, 0, 127, 0);
    queue_cmd(CMD_READ, 127, 127, 0);
    wait_drained();

    // Smallest grid with an interior, under the opposite coefficient extremes.
    configure(131071, -131072, -131072, 3, 3);
    queue_cmd(CMD_WRITE, 1, 1, 100);
    queue_cmd(CMD_WRITE, 0, 1, -200);
    queue_cmd(CMD_STEP, 0, 0, 0);
    queue_cmd(CMD_READ, 1, 1, 0);
    wait_drained();

    // Two rows only: a step updates nothing but still swaps the grids, so the
    // add made to the current grid disappears.
    configure(COEF_CENTER_RST, COEF_PREVIOUS_RST, COEF_NEIGHBOUR_RST, 5, 2);
    queue_cmd(CMD_WRITE, 1, 1, 300);
    queue_cmd(CMD_ADD, 1, 1, 50);
    queue_cmd(CMD_STEP, 0, 0, 0);
    queue_cmd(CMD_READ, 1, 1, 0);
    wait_drained();

    // No columns at all: every address is outside, and a step only swaps.
    configure(COEF_CENTER_RST, COEF_PREVIOUS_RST, COEF_NEIGHBOUR_RST, 0, 128);
    queue_cmd(CMD_WRITE, 0, 0, 5);
    queue_cmd(CMD_STEP, 0, 0, 0);
    wait_drained();

    // Random phases on grids small enough to keep steps short. Odd phases use
    // coefficients near the reset ones, so the surface stays mostly in range;
    // even phases use any coefficient. Phases 1 and 3 stretch one dimension
    // far enough to reach the upper address bits.
    for (p = 0; p < 4; p++) begin
      case (p)
        1: begin
          dim_r = $urandom_range(3, 5);
          dim_c = $urandom_range(64, 128);
        end
        3: begin
          dim_r = $urandom_range(64, 128);
          dim_c = $urandom_range(3, 5);
        end
        default: begin
          dim_r = $urandom_range(3, 12);
          dim_c = $urandom_range(3, 12);
        end
      endcase
      if (p % 2 == 1) begin
        configure(COEF_CENTER_RST + int'($urandom_range(2000)) - 1000,
                  COEF_PREVIOUS_RST + int'($urandom_range(2000)) - 1000,
                  $urandom_range(8000), dim_c, dim_r);
      end else begin
        configure($urandom, $urandom, $urandom, dim_c, dim_r);
      end
      // One phase runs with neither side ever idling.
      send_idle_pct = (p == 2) ? 0 : 19;
      take_stall_pct = (p == 2) ? 0 : 19;
      for (n = 0; n < 12; n++) queue_random();
      // Once, the sender holds off until the block has answered everything.
      if (p == 1) wait_drained();
      for (n = 0; n < 13; n++) queue_random();
      wait_drained();
    end

    repeat (TAIL_CYCLES) @(posedge clk_i);

    $display("Covered %0d writes, %0d adds, %0d steps and %0d reads over %0d grid settings.",
             cmd_seen[CMD_WRITE], cmd_seen[CMD_ADD], cmd_seen[CMD_STEP],
             cmd_seen[CMD_READ], settings_used);
    $display("Checked %0d result items, %0d of them with clipping.",
             results_checked, clipped_seen);
    if (err_count == 0) begin
      $display("wave_surface_grid_step_tb: clean");
    end else begin
      $display("wave_surface_grid_step_tb: errors");
    end
    $finish;
  end

endmodule

/* sim.f */
rtl/wsg_pkg.sv
rtl/wave_surface_grid_step.sv
tb/wave_surface_grid_step_tb.sv
